// ===== design/cba_pkg.sv =====
package cba_pkg;

    localparam int MAX_CHANNELS_DEF = 1024;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 10;
    localparam int ELEM_W    = 20;
    localparam int LEN_W     = 21;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] Q_SIX = 32'sd393216;
    localparam logic [LEN_W-1:0] LEN_MAX = 21'd1048576;
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd1024;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELU  = 2'd1,
        ACT_RELU6 = 2'd2,
        ACT_LEAKY = 2'd3
    } t_act;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVATION     = 3'd0,
        CFG_LEAK_SLOPE     = 3'd1,
        CFG_CHANNEL_LENGTH = 3'd2,
        CFG_CHANNEL_COUNT  = 3'd3,
        CFG_BIAS_ENABLE    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic channel_last;
        logic tensor_last;
    } t_tag;

endpackage

// ===== design/cba_in_if.sv =====
interface cba_in_if
    import cba_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [IDX_W-1:0]         bias_index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, mode, bias_index, value, input ready);
    modport sink (input valid, mode, bias_index, value, output ready);
endinterface

// ===== design/cba_out_if.sv =====
interface cba_out_if
    import cba_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic                     channel_last;
    logic                     tensor_last;

    modport source (output valid, result, channel_last, tensor_last, input ready);
    modport sink (input valid, result, channel_last, tensor_last, output ready);
endinterface

// ===== design/cba_bias_mem.sv =====
module cba_bias_mem
    import cba_pkg::*;
#(
    parameter int DEPTH = MAX_CHANNELS_DEF,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/channel_bias_activation.sv =====
// channel     dir  payload                                  accepted when
// i_in        in   mode, bias_index, value                  valid && ready
// o_out       out  result, channel_last, tensor_last        valid && ready
// i_cfg_*     in   i_cfg_idx, i_cfg_data                    i_cfg_we
//
// one word per cycle sustained while o_out is ready; a data word passes stages 1, 2, 3 and the output register to o_out
// bias table read is a registered synchronous memory read, then add, multiply, round stages
// bias-load words make no output word
// reset clears counters, stage valid bits and configuration registers; the bias table is not cleared
// a stalled o_out backs up stage by stage, i_in.ready drops only when every stage is full
module channel_bias_activation
    import cba_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    cba_in_if.sink               i_in,
    cba_out_if.source            o_out
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // configuration
    t_act                     r_act;
    logic signed [DATA_W-1:0] r_slope;
    logic [LEN_W-1:0]         r_len_eff;
    logic [CNT_W-1:0]         r_cnt_eff;
    logic                     r_bias_en;

    logic [LEN_W-1:0] n_len_eff;
    logic [CNT_W-1:0] n_cnt_eff;

    always_comb begin
        n_len_eff = i_cfg_data[LEN_W-1:0];
        if (n_len_eff == '0) begin
            n_len_eff = LEN_W'(1);
        end else if (n_len_eff > LEN_MAX) begin
            n_len_eff = LEN_MAX;
        end
        n_cnt_eff = i_cfg_data[CNT_W-1:0];
        if (n_cnt_eff == '0) begin
            n_cnt_eff = CNT_W'(1);
        end else if (n_cnt_eff > CNT_MAX) begin
            n_cnt_eff = CNT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= ACT_NONE;
            r_slope   <= '0;
            r_len_eff <= LEN_W'(1);
            r_cnt_eff <= CNT_W'(1);
            r_bias_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVATION:     r_act     <= t_act'(i_cfg_data[1:0]);
                CFG_LEAK_SLOPE:     r_slope   <= signed'(i_cfg_data);
                CFG_CHANNEL_LENGTH: r_len_eff <= n_len_eff;
                CFG_CHANNEL_COUNT:  r_cnt_eff <= n_cnt_eff;
                CFG_BIAS_ENABLE:    r_bias_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic r_v1, r_v2, r_v3, r_vo;
    logic free_o, free3, free2, free1;

    assign free_o = !r_vo || o_out.ready;
    assign free3  = !r_v3 || free_o;
    assign free2  = !r_v2 || free3;
    assign free1  = !r_v1 || free2;

    assign i_in.ready = free1;

    logic acc, acc_data, acc_load;
    assign acc      = i_in.valid && free1;
    assign acc_data = acc && i_in.mode;
    assign acc_load = acc && !i_in.mode;

    // position counters
    logic [ELEM_W-1:0] r_elem;
    logic [IDX_W-1:0]  r_chan;
    logic              n_cl, n_tl;

    always_comb begin
        n_cl = ({1'b0, r_elem} + LEN_W'(1)) >= r_len_eff;
        n_tl = n_cl && (({1'b0, r_chan} + CNT_W'(1)) >= r_cnt_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem <= '0;
            r_chan <= '0;
        end else if (acc_data) begin
            if (n_cl) begin
                r_elem <= '0;
                r_chan <= n_tl ? '0 : r_chan + IDX_W'(1);
            end else begin
                r_elem <= r_elem + ELEM_W'(1);
            end
        end
    end

    // bias table
    logic [31:0]       w_widx, w_ridx;
    logic              mem_we;
    logic [DATA_W-1:0] bias_q;
    logic              n_bias_use;

    assign w_widx     = 32'(i_in.bias_index);
    assign w_ridx     = 32'(r_chan);
    assign mem_we     = acc_load && (w_widx < 32'(MAX_CHANNELS));
    assign n_bias_use = r_bias_en && (w_ridx < 32'(MAX_CHANNELS));

    cba_bias_mem #(
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_bias_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (w_widx[AW-1:0]),
        .i_wdata (i_in.value),
        .i_re    (acc_data),
        .i_raddr (w_ridx[AW-1:0]),
        .o_rdata (bias_q)
    );

    // stage 1: element waits for its bias word
    logic signed [DATA_W-1:0] r_val1;
    logic                     r_bias_use1;
    t_tag                     r_tag1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (free1) begin
            r_v1 <= acc_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_data) begin
            r_val1      <= i_in.value;
            r_bias_use1 <= n_bias_use;
            r_tag1      <= '{channel_last: n_cl, tensor_last: n_tl};
        end
    end

    // stage 2: saturated bias add
    logic signed [DATA_W-1:0] bias_sel;
    logic signed [DATA_W:0]   sum_wide;
    logic signed [DATA_W-1:0] n_sum;

    always_comb begin
        bias_sel = r_bias_use1 ? signed'(bias_q) : '0;
        sum_wide = {r_val1[DATA_W-1], r_val1} + {bias_sel[DATA_W-1], bias_sel};
        if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
            n_sum = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_sum = sum_wide[DATA_W-1:0];
        end
    end

    logic signed [DATA_W-1:0] r_sum2;
    t_tag                     r_tag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (free2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free2 && r_v1) begin
            r_sum2 <= n_sum;
            r_tag2 <= r_tag1;
        end
    end

    // stage 3: leaky slope product
    logic signed [2*DATA_W-1:0] r_prod3;
    logic signed [DATA_W-1:0]   r_sum3;
    t_tag                       r_tag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (free3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free3 && r_v2) begin
            r_prod3 <= r_sum2 * r_slope;
            r_sum3  <= r_sum2;
            r_tag3  <= r_tag2;
        end
    end

    // output stage: round, saturate, pick activation
    logic signed [2*DATA_W-1:0] rnd;
    logic signed [DATA_W-1:0]   leak_res;
    logic signed [DATA_W-1:0]   n_res;

    always_comb begin
        rnd = r_prod3 + 64'sd32768;
        // rnd >>> 16 must fit in 32 bits: bits 63..47 all equal
        if (!rnd[63] && (|rnd[62:47])) begin
            leak_res = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (rnd[63] && !(&rnd[62:47])) begin
            leak_res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            leak_res = rnd[47:16];
        end

        unique case (r_act)
            ACT_RELU:  n_res = r_sum3[DATA_W-1] ? '0 : r_sum3;
            ACT_RELU6: begin
                if (r_sum3[DATA_W-1]) begin
                    n_res = '0;
                end else if (r_sum3 > Q_SIX) begin
                    n_res = Q_SIX;
                end else begin
                    n_res = r_sum3;
                end
            end
            ACT_LEAKY: n_res = r_sum3[DATA_W-1] ? leak_res : r_sum3;
            default:   n_res = r_sum3;
        endcase
    end

    logic signed [DATA_W-1:0] r_res_o;
    t_tag                     r_tag_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (free_o) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_o && r_v3) begin
            r_res_o <= n_res;
            r_tag_o <= r_tag3;
        end
    end

    assign o_out.valid        = r_vo;
    assign o_out.result       = r_res_o;
    assign o_out.channel_last = r_tag_o.channel_last;
    assign o_out.tensor_last  = r_tag_o.tensor_last;

    // checks
    a_tensor_ends_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.tensor_last |-> o_out.channel_last)
        else $error("tensor_last without channel_last");

    a_relu_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (r_act == ACT_RELU || r_act == ACT_RELU6) |-> !o_out.result[DATA_W-1])
        else $error("negative result under relu");

    a_relu6_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_act == ACT_RELU6 |-> o_out.result <= Q_SIX)
        else $error("relu6 result above ceiling");

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_load |=> !r_v1)
        else $error("bias load entered the pipeline");

endmodule

// ===== verif/channel_bias_activation_tb.sv =====
module channel_bias_activation_tb;
    import cba_pkg::*;

    localparam logic MODE_BIAS = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;

    localparam int N_PHASES = 12;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_FILL = 8;

    typedef struct packed {
        logic                     mode;
        logic [IDX_W-1:0]         bias_index;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     channel_last;
        logic                     tensor_last;
    } t_out_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    cba_in_if  in_ch ();
    cba_out_if out_ch ();

    channel_bias_activation u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // register shadow, written only while the block is idle
    t_act                     act_reg;
    logic signed [DATA_W-1:0] slope_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     bias_en_reg;

    // predictor state
    logic signed [DATA_W-1:0] bias_mem [0:MAX_CHANNELS_DEF-1];
    logic [ELEM_W-1:0]        elem_pos;
    logic [IDX_W-1:0]         chan_pos;

    t_in_word  words_to_send [$];
    t_out_word activated_q [$];

    logic      in_fire;
    logic      out_fire;
    logic      tx_burst;
    logic      rx_burst;
    logic      rx_hold = 1'b0;
    logic      hold_go = 1'b0;
    int        tx_wait;
    int        rx_wait;
    int        err_cnt;
    int        n_checked;
    int        n_bias_loads;
    int        n_cfg_writes;
    t_in_word  tx_word;
    t_out_word exp_w;
    t_out_word pred_w;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
            sat32 = Q_MAX;
        else if (v < -64'sh0000_0000_8000_0000)
            sat32 = Q_MIN;
        else
            sat32 = v[DATA_W-1:0];
    endfunction

    task automatic bias_activate(input logic signed [DATA_W-1:0] x, output t_out_word y);
        logic signed [DATA_W-1:0] bias;
        logic signed [DATA_W-1:0] sum;
        logic signed [DATA_W-1:0] res;
        logic signed [63:0]       prod;
        logic [LEN_W-1:0]         len;
        logic [CNT_W-1:0]         cnt;
        logic                     ch_last;
        logic                     t_last;
        bias = bias_en_reg ? bias_mem[chan_pos] : '0;
        sum = sat32(64'(x) + 64'(bias));
        case (act_reg)
            ACT_RELU: res = (sum < 0) ? '0 : sum;
            ACT_RELU6: res = (sum < 0) ? '0 : ((sum > Q_SIX) ? Q_SIX : sum);
            ACT_LEAKY: begin
                if (sum >= 0) begin
                    res = sum;
                end else begin
                    prod = 64'(sum) * 64'(slope_reg);
                    // round to nearest, ties toward +inf
                    res = sat32((prod + 64'sd32768) >>> 16);
                end
            end
            default: res = sum;
        endcase
        len = (len_reg == '0) ? LEN_W'(1) : ((len_reg > LEN_MAX) ? LEN_MAX : len_reg);
        cnt = (cnt_reg == '0) ? CNT_W'(1) : ((cnt_reg > CNT_MAX) ? CNT_MAX : cnt_reg);
        ch_last = (LEN_W'(elem_pos) + LEN_W'(1)) >= len;
        t_last = ch_last && ((CNT_W'(chan_pos) + CNT_W'(1)) >= cnt);
        if (ch_last) begin
            elem_pos = '0;
            chan_pos = t_last ? '0 : chan_pos + 1'b1;
        end else begin
            elem_pos = elem_pos + 1'b1;
        end
        y.result = res;
        y.channel_last = ch_last;
        y.tensor_last = t_last;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_q();
        case ($urandom_range(0, 9))
            0: rand_q = Q_MAX;
            1: rand_q = Q_MIN;
            2: rand_q = $signed($urandom_range(0, 2 * 393216)) - 32'sd393216;
            3: rand_q = Q_SIX + $signed($urandom_range(0, 8)) - 32'sd4;
            4: rand_q = $signed($urandom_range(0, 64)) - 32'sd32;
            default: rand_q = $signed($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_slope();
        case ($urandom_range(0, 5))
            0: rand_slope = Q_MIN;
            1: rand_slope = Q_MAX;
            2: rand_slope = $signed($urandom);
            3: rand_slope = $signed($urandom_range(0, 32'h0002_0000));
            default: rand_slope = $signed($urandom_range(0, 32'h0001_0000));
        endcase
    endfunction

    task automatic push_word(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] v);
        t_in_word w;
        w.mode = mode;
        w.bias_index = idx;
        w.value = v;
        words_to_send.push_back(w);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVATION: act_reg = t_act'(data[1:0]);
            CFG_LEAK_SLOPE: slope_reg = data;
            CFG_CHANNEL_LENGTH: len_reg = data[LEN_W-1:0];
            CFG_CHANNEL_COUNT: cnt_reg = data[CNT_W-1:0];
            CFG_BIAS_ENABLE: bias_en_reg = data[0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic set_config(input t_act a, input logic [DATA_W-1:0] slope,
                              input logic [LEN_W-1:0] len, input logic [CNT_W-1:0] cnt,
                              input logic ben);
        write_reg(CFG_ACTIVATION, DATA_W'(a));
        write_reg(CFG_LEAK_SLOPE, slope);
        write_reg(CFG_CHANNEL_LENGTH, DATA_W'(len));
        write_reg(CFG_CHANNEL_COUNT, DATA_W'(cnt));
        write_reg(CFG_BIAS_ENABLE, DATA_W'(ben));
    endtask

    // bias loads make no output word, so give the pipe time to settle too
    // checked at the rising edge, where the sender's state is settled
    task automatic wait_drained();
        while (words_to_send.size() != 0 || in_ch.valid || activated_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("channel_bias_activation_tb: done, errors");
        $finish;
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_fire) begin
            // word still waiting for ready
        end else if (tx_wait > 0) begin
            in_ch.valid <= 1'b0;
            tx_wait--;
        end else if (words_to_send.size() != 0) begin
            tx_word = words_to_send.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.mode <= tx_word.mode;
            in_ch.bias_index <= tx_word.bias_index;
            in_ch.value <= tx_word.value;
            tx_wait = tx_burst ? 0 : $urandom_range(0, 10);
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (out_fire)
            rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
        if (rx_hold) begin
            out_ch.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            out_ch.ready <= 1'b0;
            rx_wait--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // long receiver stall, counted here so the sender keeps offering
    initial begin : rx_hold_ctl
        int hold_cyc;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                rx_hold <= 1'b1;
                for (hold_cyc = 0; hold_cyc < HOLD_CYCLES; hold_cyc++)
                    @(negedge i_clk);
                rx_hold <= 1'b0;
            end
        end
    end

    // predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        out_fire <= i_rst_n && out_ch.valid && out_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (in_ch.mode == MODE_DATA) begin
                bias_activate(in_ch.value, pred_w);
                activated_q.push_back(pred_w);
            end else begin
                bias_mem[in_ch.bias_index] = in_ch.value;
                n_bias_loads++;
            end
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (activated_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected output word: result %0d channel_last %0b tensor_last %0b",
                             out_ch.result, out_ch.channel_last, out_ch.tensor_last);
            end else begin
                exp_w = activated_q.pop_front();
                if (out_ch.result !== exp_w.result || out_ch.channel_last !== exp_w.channel_last
                    || out_ch.tensor_last !== exp_w.tensor_last) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch on word %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 n_checked, exp_w.result, exp_w.channel_last,
                                 exp_w.tensor_last, out_ch.result, out_ch.channel_last,
                                 out_ch.tensor_last);
                end
                n_checked++;
            end
        end
    end

    initial begin : main_seq
        int p;
        int k;
        int n_items;
        int a;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic signed [DATA_W-1:0] slope;
        logic [IDX_W-1:0] idx;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_BIAS;
        in_ch.bias_index = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        tx_wait = 0;
        rx_wait = 0;
        err_cnt = 0;
        n_checked = 0;
        n_bias_loads = 0;
        n_cfg_writes = 0;
        act_reg = ACT_NONE;
        slope_reg = '0;
        len_reg = LEN_W'(1);
        cnt_reg = CNT_W'(1);
        bias_en_reg = 1'b0;
        elem_pos = '0;
        chan_pos = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every word ends its channel and its tensor
        @(posedge i_clk);
        push_word(MODE_DATA, '1, Q_MAX);
        push_word(MODE_DATA, '0, Q_MIN);
        push_word(MODE_DATA, '0, '0);
        wait_drained();

        // fill every entry the channel counter reaches (it stays below N_FILL)
        @(posedge i_clk);
        rx_burst = 1'b1;
        for (k = 0; k < N_FILL; k++) begin
            case (k)
                0: push_word(MODE_BIAS, IDX_W'(k), Q_MAX);
                1: push_word(MODE_BIAS, IDX_W'(k), Q_MIN);
                2: push_word(MODE_BIAS, IDX_W'(k), Q_SIX);
                default: push_word(MODE_BIAS, IDX_W'(k), rand_q());
            endcase
        end
        wait_drained();

        // each activation on the extremes, bias saturation on the first ones
        for (a = 0; a < 4; a++) begin
            set_config(t_act'(a), Q_HALF, LEN_W'(2), CNT_W'(3), a < 2);
            @(posedge i_clk);
            rx_burst = 1'b0;
            push_word(MODE_DATA, IDX_W'($urandom), Q_MAX);
            push_word(MODE_DATA, IDX_W'($urandom), Q_MIN);
            push_word(MODE_DATA, IDX_W'($urandom), -32'sd1);
            push_word(MODE_DATA, IDX_W'($urandom), Q_SIX + 32'sd1);
            push_word(MODE_DATA, IDX_W'($urandom), Q_SIX);
            wait_drained();
        end

        for (p = 0; p < N_PHASES; p++) begin
            n_items = 60;
            case (p)
                0: set_config(ACT_LEAKY, Q_MIN, '0, '0, 1'b1);
                1: begin
                    set_config(ACT_LEAKY, Q_MAX, LEN_MAX, CNT_MAX, 1'b1);
                    n_items = 8;
                end
                2: begin
                    set_config(ACT_RELU6, '0, '1, '1, 1'b0);
                    n_items = 8;
                end
                default: begin
                    len = LEN_W'($urandom_range(1, 6));
                    cnt = CNT_W'($urandom_range(1, 5));
                    slope = rand_slope();
                    set_config(t_act'(p % 4), slope, len, cnt, 1'($urandom_range(0, 1)));
                end
            endcase
            @(posedge i_clk);
            tx_burst = (p % 4 == 3);
            rx_burst = (p % 5 == 4);
            for (k = 0; k < n_items; k++) begin
                idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 7))
                                                  : IDX_W'($urandom);
                if ($urandom_range(0, 9) < 2)
                    push_word(MODE_BIAS, idx, rand_q());
                else
                    push_word(MODE_DATA, idx, rand_q());
            end
            // back up the whole pipe while the sender keeps going
            if (p == 3)
                hold_go = 1'b1;
            wait_drained();
        end

        $display("summary: %0d output words checked, %0d bias loads, %0d register writes",
                 n_checked, n_bias_loads, n_cfg_writes);
        $display("summary: all activations, saturating bias and slopes, size limits, long stall");
        if (err_cnt == 0) begin
            $display("channel_bias_activation_tb: done, clean");
        end else begin
            $display("%0d mismatches in total", err_cnt);
            $display("channel_bias_activation_tb: done, errors");
        end
        $finish;
    end

endmodule
